// File: hw/rtl/v3alu_pkg.sv
// Shared types, opcodes and helpers for the 3D vector arithmetic unit.
package v3alu_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QW          = 32;
  localparam int unsigned ThrW        = 31;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned RadW        = 64;
  localparam int unsigned SqRemW      = 33;
  localparam int unsigned WideW       = 67;
  localparam logic [ThrW-1:0] ThrReset = 31'd1;

  typedef enum logic [3:0] {
    CMD_ADD       = 4'd0,
    CMD_SUB       = 4'd1,
    CMD_NEGATE    = 4'd2,
    CMD_DOT       = 4'd3,
    CMD_CROSS     = 4'd4,
    CMD_SCALE     = 4'd5,
    CMD_DIVIDE    = 4'd6,
    CMD_NORM      = 4'd7,
    CMD_NORMSQ    = 4'd8,
    CMD_NORMALIZE = 4'd9,
    CMD_EQUAL     = 4'd10
  } cmd_e;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    logic [3:0] cmd;
    q_t         a_x;
    q_t         a_y;
    q_t         a_z;
    q_t         b_x;
    q_t         b_y;
    q_t         b_z;
    q_t         scalar;
  } in_t;

  typedef struct packed {
    q_t   r_x;
    q_t   r_y;
    q_t   r_z;
    logic is_equal;
    logic saturated;
    logic div_fault;
  } out_t;

  // partial result travelling down the cell chains
  typedef struct packed {
    logic [2:0][QW-1:0] r;
    logic               sat;
    logic               eq;
    logic               fault;
    logic               use_div;
  } res_t;

  typedef struct packed {
    res_t               res;
    logic [3:0]         cmd;
    logic [2:0][QW-1:0] a;
    logic [QW-1:0]      s;
  } ctx_t;

  localparam logic signed [WideW-1:0] QMaxW = 67'sd2147483647;
  localparam logic signed [WideW-1:0] QMinW = -67'sd2147483648;

  // {sat, value}
  function automatic logic [QW:0] clip32(input logic signed [WideW-1:0] v);
    logic [QW:0] o;
    if (v > QMaxW) begin
      o = {1'b1, 32'h7FFF_FFFF};
    end else if (v < QMinW) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, v[QW-1:0]};
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/v3alu_sqrt_cell.sv
// One bit step of the square root chain; forwards the item context.
module v3alu_sqrt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  v3alu_pkg::ctx_t                ctx_i,
  input  logic [v3alu_pkg::RadW-1:0]     rad_i,
  input  logic [v3alu_pkg::SqRemW-1:0]   rem_i,
  input  logic [v3alu_pkg::QW-1:0]       root_i,
  output logic                           valid_o,
  output v3alu_pkg::ctx_t                ctx_o,
  output logic [v3alu_pkg::RadW-1:0]     rad_o,
  output logic [v3alu_pkg::SqRemW-1:0]   rem_o,
  output logic [v3alu_pkg::QW-1:0]       root_o
);

  logic [v3alu_pkg::SqRemW+1:0] t, trial, diff;
  logic [v3alu_pkg::SqRemW-1:0] rem_d;
  logic [v3alu_pkg::QW-1:0]     root_d;

  always_comb begin
    t     = {rem_i, rad_i[v3alu_pkg::RadW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      rem_d  = diff[v3alu_pkg::SqRemW-1:0];
      root_d = {root_i[v3alu_pkg::QW-2:0], 1'b1};
    end else begin
      rem_d  = t[v3alu_pkg::SqRemW-1:0];
      root_d = {root_i[v3alu_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_o  <= ctx_i;
    rad_o  <= {rad_i[v3alu_pkg::RadW-3:0], 2'b00};
    rem_o  <= rem_d;
    root_o <= root_d;
  end

endmodule

// File: hw/rtl/v3alu_div_cell.sv
// One quotient bit step for three divider lanes sharing one divisor.
module v3alu_div_cell #(
  parameter int unsigned NW = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  v3alu_pkg::res_t               res_i,
  input  logic [v3alu_pkg::QW-1:0]      d_i,
  input  logic [2:0][NW-1:0]            nq_i,
  input  logic [2:0][v3alu_pkg::QW-1:0] rem_i,
  input  logic [2:0]                    neg_i,
  output logic                          valid_o,
  output v3alu_pkg::res_t               res_o,
  output logic [v3alu_pkg::QW-1:0]      d_o,
  output logic [2:0][NW-1:0]            nq_o,
  output logic [2:0][v3alu_pkg::QW-1:0] rem_o,
  output logic [2:0]                    neg_o
);

  logic [2:0][NW-1:0]            nq_d;
  logic [2:0][v3alu_pkg::QW-1:0] rem_d;
  logic [v3alu_pkg::QW:0]        t, diff;

  // numerator bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    nq_d  = nq_i;
    rem_d = rem_i;
    t     = '0;
    diff  = '0;
    for (int i = 0; i < 3; i++) begin
      t    = {rem_i[i], nq_i[i][NW-1]};
      diff = t - {1'b0, d_i};
      if (t >= {1'b0, d_i}) begin
        rem_d[i] = diff[v3alu_pkg::QW-1:0];
        nq_d[i]  = {nq_i[i][NW-2:0], 1'b1};
      end else begin
        rem_d[i] = t[v3alu_pkg::QW-1:0];
        nq_d[i]  = {nq_i[i][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_i;
    d_o   <= d_i;
    nq_o  <= nq_d;
    rem_o <= rem_d;
    neg_o <= neg_i;
  end

endmodule

// File: hw/rtl/vector3_arithmetic_unit.sv
// Throughput: one item per cycle; busy_o stays low, every item flows down the
// same pipe: input register, multiply, sum, 32 square root cells, divider setup,
// 32+FRAC_BITS divider cells, output register.
// Result beats appear on done_o for one cycle each, in input order.
// Reset clears the pipe valid bits and sets the tiny norm threshold to 1.
// Top level of the 3D vector unit.
module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = v3alu_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  v3alu_pkg::in_t             in_i,
  input  logic                       cfg_we_i,
  input  logic [v3alu_pkg::ThrW-1:0] cfg_wdata_i,
  output logic                       done_o,
  output v3alu_pkg::out_t            res_o
);

  localparam int unsigned NW  = v3alu_pkg::QW + FRAC_BITS;
  localparam int unsigned SQN = v3alu_pkg::SqrtSteps;
  localparam int unsigned LAT = NW + 37;
  localparam int unsigned QW  = v3alu_pkg::QW;
  localparam int unsigned WW  = v3alu_pkg::WideW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic [v3alu_pkg::ThrW-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= v3alu_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage 1: input register
  logic           v1_q;
  v3alu_pkg::in_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  // ---------------- stage 2: multipliers, add/sub/negate and equality compare
  logic signed [QW-1:0]   op_a [6];
  logic signed [QW-1:0]   op_b [6];
  logic signed [2*QW-1:0] p_d [6];
  logic signed [2*QW-1:0] p_q [6];
  logic                   v2_q;
  v3alu_pkg::ctx_t        c2_d, c2_q;
  logic [2:0][QW-1:0]     va, vb;
  logic signed [WW-1:0]   wsum;
  logic [QW:0]            cl;

  always_comb begin
    va = {in_q.a_z, in_q.a_y, in_q.a_x};
    vb = {in_q.b_z, in_q.b_y, in_q.b_x};
    for (int i = 0; i < 6; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    c2_d         = '0;
    c2_d.cmd     = in_q.cmd;
    c2_d.a       = va;
    c2_d.s       = in_q.scalar;
    wsum         = '0;
    cl           = '0;
    case (v3alu_pkg::cmd_e'(in_q.cmd))
      v3alu_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = va[i];
          op_b[i] = vb[i];
        end
      end
      v3alu_pkg::CMD_CROSS: begin
        op_a[0] = va[1]; op_b[0] = vb[2];
        op_a[1] = va[2]; op_b[1] = vb[1];
        op_a[2] = va[2]; op_b[2] = vb[0];
        op_a[3] = va[0]; op_b[3] = vb[2];
        op_a[4] = va[0]; op_b[4] = vb[1];
        op_a[5] = va[1]; op_b[5] = vb[0];
      end
      v3alu_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = va[i];
          op_b[i] = in_q.scalar;
        end
      end
      v3alu_pkg::CMD_NORM, v3alu_pkg::CMD_NORMSQ, v3alu_pkg::CMD_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = va[i];
          op_b[i] = va[i];
        end
      end
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_NEGATE: begin
        for (int i = 0; i < 3; i++) begin
          if (in_q.cmd == v3alu_pkg::CMD_ADD) begin
            wsum = WW'($signed(va[i])) + WW'($signed(vb[i]));
          end else if (in_q.cmd == v3alu_pkg::CMD_SUB) begin
            wsum = WW'($signed(va[i])) - WW'($signed(vb[i]));
          end else begin
            wsum = -WW'($signed(va[i]));
          end
          cl = v3alu_pkg::clip32(wsum);
          c2_d.res.r[i] = cl[QW-1:0];
          c2_d.res.sat  = c2_d.res.sat | cl[QW];
        end
      end
      v3alu_pkg::CMD_EQUAL: begin
        c2_d.res.eq = (va == vb);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      p_d[i] = op_a[i] * op_b[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    c2_q <= c2_d;
    for (int i = 0; i < 6; i++) begin
      p_q[i] <= p_d[i];
    end
  end

  // ---------------- stage 3: product sums, floor shift and clip
  logic                   v3_q;
  v3alu_pkg::ctx_t        c3_d, c3_q;
  logic [63:0]            sq_d, sq_q;
  logic signed [WW-1:0]   acc;
  logic [QW:0]            cl3;
  logic [63:0]            nsq;

  always_comb begin
    c3_d = c2_q;
    sq_d = 64'(p_q[0]) + 64'(p_q[1]) + 64'(p_q[2]);
    nsq  = sq_d >> FRAC_BITS;
    acc  = '0;
    cl3  = '0;
    case (v3alu_pkg::cmd_e'(c2_q.cmd))
      v3alu_pkg::CMD_DOT: begin
        acc = (WW'(p_q[0]) + WW'(p_q[1]) + WW'(p_q[2])) >>> FRAC_BITS;
        cl3 = v3alu_pkg::clip32(acc);
        c3_d.res.r[0] = cl3[QW-1:0];
        c3_d.res.sat  = cl3[QW];
      end
      v3alu_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          acc = (WW'(p_q[2*i]) - WW'(p_q[2*i+1])) >>> FRAC_BITS;
          cl3 = v3alu_pkg::clip32(acc);
          c3_d.res.r[i] = cl3[QW-1:0];
          c3_d.res.sat  = c3_d.res.sat | cl3[QW];
        end
      end
      v3alu_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          acc = WW'(p_q[i]) >>> FRAC_BITS;
          cl3 = v3alu_pkg::clip32(acc);
          c3_d.res.r[i] = cl3[QW-1:0];
          c3_d.res.sat  = c3_d.res.sat | cl3[QW];
        end
      end
      v3alu_pkg::CMD_NORMSQ: begin
        if (nsq > 64'h7FFF_FFFF) begin
          c3_d.res.r[0] = 32'h7FFF_FFFF;
          c3_d.res.sat  = 1'b1;
        end else begin
          c3_d.res.r[0] = nsq[QW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    c3_q <= c3_d;
    sq_q <= sq_d;
  end

  // ---------------- square root chain
  logic                                sv   [SQN+1];
  v3alu_pkg::ctx_t                     sc   [SQN+1];
  logic [v3alu_pkg::RadW-1:0]          srad [SQN+1];
  logic [v3alu_pkg::SqRemW-1:0]        srem [SQN+1];
  logic [QW-1:0]                       sroot[SQN+1];

  assign sv[0]    = v3_q;
  assign sc[0]    = c3_q;
  assign srad[0]  = sq_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    v3alu_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[k]),
      .ctx_i  (sc[k]),
      .rad_i  (srad[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .valid_o(sv[k+1]),
      .ctx_o  (sc[k+1]),
      .rad_o  (srad[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1])
    );
  end

  // ---------------- divider setup
  v3alu_pkg::ctx_t    cs;
  logic [QW-1:0]      n;
  v3alu_pkg::res_t    su_res_d, su_res_q;
  logic [QW-1:0]      su_d_d, su_d_q;
  logic [2:0][NW-1:0] su_nq_d, su_nq_q;
  logic [2:0]         su_neg_d, su_neg_q;
  logic [QW-1:0]      mag;
  logic               sv_q;

  always_comb begin
    cs       = sc[SQN];
    n        = sroot[SQN];
    su_res_d = cs.res;
    su_d_d   = '0;
    su_neg_d = '0;
    su_nq_d  = '0;
    mag      = '0;
    for (int i = 0; i < 3; i++) begin
      mag        = cs.a[i][QW-1] ? (~cs.a[i] + 1'b1) : cs.a[i];
      su_nq_d[i] = {mag, FRAC_BITS'(0)};
    end
    case (v3alu_pkg::cmd_e'(cs.cmd))
      v3alu_pkg::CMD_NORM: begin
        if (n[QW-1]) begin
          su_res_d.r[0] = 32'h7FFF_FFFF;
          su_res_d.sat  = 1'b1;
        end else begin
          su_res_d.r[0] = n;
        end
      end
      v3alu_pkg::CMD_NORMALIZE: begin
        if (n == '0 || n < {1'b0, thr_q}) begin
          su_res_d.r     = cs.a;
          su_res_d.fault = 1'b1;
        end else begin
          su_res_d.use_div = 1'b1;
          su_d_d           = n;
          for (int i = 0; i < 3; i++) begin
            su_neg_d[i] = cs.a[i][QW-1];
          end
        end
      end
      v3alu_pkg::CMD_DIVIDE: begin
        if (cs.s == '0) begin
          su_res_d.fault = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (cs.a[i][QW-1]) begin
              su_res_d.r[i] = 32'h8000_0000;
              su_res_d.sat  = 1'b1;
            end else if (cs.a[i] != '0) begin
              su_res_d.r[i] = 32'h7FFF_FFFF;
              su_res_d.sat  = 1'b1;
            end
          end
        end else begin
          su_res_d.use_div = 1'b1;
          su_d_d           = cs.s[QW-1] ? (~cs.s + 1'b1) : cs.s;
          for (int i = 0; i < 3; i++) begin
            su_neg_d[i] = cs.a[i][QW-1] ^ cs.s[QW-1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= sv[SQN];
    end
  end
  always_ff @(posedge clk_i) begin
    su_res_q <= su_res_d;
    su_d_q   <= su_d_d;
    su_nq_q  <= su_nq_d;
    su_neg_q <= su_neg_d;
  end

  // ---------------- divider chain
  logic                    dv   [NW+1];
  v3alu_pkg::res_t         dres [NW+1];
  logic [QW-1:0]           dd   [NW+1];
  logic [2:0][NW-1:0]      dnq  [NW+1];
  logic [2:0][QW-1:0]      drem [NW+1];
  logic [2:0]              dneg [NW+1];

  assign dv[0]   = sv_q;
  assign dres[0] = su_res_q;
  assign dd[0]   = su_d_q;
  assign dnq[0]  = su_nq_q;
  assign drem[0] = '0;
  assign dneg[0] = su_neg_q;

  for (genvar j = 0; j < NW; j++) begin : g_div
    v3alu_div_cell #(
      .NW(NW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[j]),
      .res_i  (dres[j]),
      .d_i    (dd[j]),
      .nq_i   (dnq[j]),
      .rem_i  (drem[j]),
      .neg_i  (dneg[j]),
      .valid_o(dv[j+1]),
      .res_o  (dres[j+1]),
      .d_o    (dd[j+1]),
      .nq_o   (dnq[j+1]),
      .rem_o  (drem[j+1]),
      .neg_o  (dneg[j+1])
    );
  end

  // ---------------- output stage: sign and clip quotients
  v3alu_pkg::res_t    fr;
  logic [NW-1:0]      q;
  logic               done_q;
  v3alu_pkg::out_t    res_d, res_q;

  always_comb begin
    fr = dres[NW];
    q  = '0;
    if (fr.use_div) begin
      for (int i = 0; i < 3; i++) begin
        q = dnq[NW][i];
        if (!dneg[NW][i]) begin
          if (q > NW'(32'h7FFF_FFFF)) begin
            fr.r[i] = 32'h7FFF_FFFF;
            fr.sat  = 1'b1;
          end else begin
            fr.r[i] = q[QW-1:0];
          end
        end else begin
          if (q > NW'(33'h1_0000_0000 >> 1)) begin
            fr.r[i] = 32'h8000_0000;
            fr.sat  = 1'b1;
          end else begin
            fr.r[i] = ~q[QW-1:0] + 1'b1;
          end
        end
      end
    end
    res_d.r_x       = fr.r[0];
    res_d.r_y       = fr.r[1];
    res_d.r_z       = fr.r[2];
    res_d.is_equal  = fr.eq;
    res_d.saturated = fr.sat;
    res_d.div_fault = fr.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv[NW];
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_lat_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result beat missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##LAT !done_o)
    else $error("result beat without an item");

  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.is_equal |-> !res_o.saturated && !res_o.div_fault && res_o.r_x == '0)
    else $error("equal result carries other fields");

  a_div_fault_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q && su_res_q.use_div |-> !su_res_q.fault && su_d_q != '0)
    else $error("divider started with zero divisor");
`endif

endmodule
